### hdl/csr_as_pkg.sv
`default_nettype none
package csr_as_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 1024;
  localparam int VAL_W       = 16;
  localparam int NODE_IDX_W  = 6;
  localparam int NODE_CNT_W  = 7;
  localparam int EDGE_CNT_W  = 11;
  localparam int EDGE_IDX_W  = 10;
  localparam int HOP_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int ACC_W       = 44;
  localparam int MUL_A_W     = 23;
  localparam int PROD_W      = 39;
  localparam int SUM_W       = 61;
  localparam int SPLIT       = 22;
  localparam int SHIFT       = 24;
  localparam int IN_DATA_W   = 48;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic [1:0] {
    CMD_ROW  = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_SEED = 2'd2,
    CMD_RUN  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_COUNT  = 3'd4;

endpackage
`default_nettype wire

### hdl/csr_activation_spreader_top.sv
`default_nettype none
// spreading activation over an incoming-edge csr graph, signed q8.8 values.
// load transactions (tuser = 0 row offset, 1 edge, 2 seed) are taken one per
// cycle. a run transaction (tuser = 3) performs hop_count synchronous hops and
// then reports every node in use, node 0 first, tlast on the final node; the
// run result stays in the activation memory so a later run continues from it.
// all arithmetic goes through one shared 23x16 signed multiplier under a small
// sequencer, and a stall on the result side holds up the reporting; the
// per-edge cost is set by the chain edge memory -> activation memory ->
// multiplier -> accumulator, and the per-node cost by the row offset reads,
// the split acc * decay product and the copy of next into current values.
// the input side is not ready while a run is in progress. an edge count of
// zero skips all hops and reports the seeds with hops_done zero.
module csr_activation_spreader_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // slot[10:0], offset[21:11], neighbor[27:22], value[43:28], zero fill
  input  wire  [csr_as_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[1:0]
  input  wire  [csr_as_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // node[5:0], activation[21:6], hops_done[29:22], zero fill
  output logic [csr_as_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                 out_tlast,
  input  wire                                  cfg_we,
  input  wire  [csr_as_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire  [csr_as_pkg::VAL_W-1:0]         cfg_wdata
);
  import csr_as_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_E1, S_E2, S_E3, S_E4,
    S_D1, S_D2, S_D3, S_D4, S_CPR, S_CPW, S_ERD, S_ECAP
  } state_t;

  // configuration registers
  logic [NODE_CNT_W-1:0]   node_count_r;
  logic [EDGE_CNT_W-1:0]   edge_count_r;
  logic signed [VAL_W-1:0] decay_r;
  logic signed [VAL_W-1:0] thr_r;
  logic [HOP_W-1:0]        hop_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      edge_count_r <= '0;
      decay_r      <= 16'sd256;
      thr_r        <= '0;
      hop_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NODE_COUNT: node_count_r <= cfg_wdata[NODE_CNT_W-1:0];
        REG_EDGE_COUNT: edge_count_r <= cfg_wdata[EDGE_CNT_W-1:0];
        REG_DECAY:      decay_r      <= cfg_wdata;
        REG_THRESHOLD:  thr_r        <= cfg_wdata;
        REG_HOP_COUNT:  hop_count_r  <= cfg_wdata[HOP_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  cmd_t                    in_cmd;
  logic [EDGE_CNT_W-1:0]   in_slot;
  logic [EDGE_CNT_W-1:0]   in_offset;
  logic [NODE_IDX_W-1:0]   in_nb;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_acc;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_slot   = in_tdata[10:0];
  assign in_offset = in_tdata[21:11];
  assign in_nb     = in_tdata[27:22];
  assign in_value  = in_tdata[43:28];

  // sequencer registers
  state_t                  state_r;
  logic [NODE_CNT_W-1:0]   i_r;
  logic [NODE_CNT_W-1:0]   n_r;
  logic [HOP_W-1:0]        h_r;
  logic [HOP_W-1:0]        hops_r;
  logic [EDGE_CNT_W-1:0]   elim_r;
  logic [EDGE_CNT_W-1:0]   e_r;
  logic [EDGE_CNT_W-1:0]   end_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [VAL_W-1:0] old_r;
  logic                    out_valid_r;
  logic [NODE_IDX_W-1:0]   out_node_r;
  logic [VAL_W-1:0]        out_act_r;
  logic [HOP_W-1:0]        out_hops_r;
  logic                    out_last_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // memories
  logic [EDGE_CNT_W-1:0]   row_mem [0:MAX_NODES];
  logic [EDGE_CNT_W-1:0]   row_q;
  logic [NODE_IDX_W-1:0]   nb_mem [0:MAX_EDGES-1];
  logic [VAL_W-1:0]        w_mem [0:MAX_EDGES-1];
  logic [NODE_IDX_W-1:0]   nb_q;
  logic signed [VAL_W-1:0] w_q;
  logic [VAL_W-1:0]        act_mem [0:MAX_NODES-1];
  logic [MAX_NODES-1:0]    act_vld_r;
  logic [VAL_W-1:0]        act_a_q, act_b_q;
  logic                    act_a_vq, act_b_vq;
  logic [VAL_W-1:0]        nxt_mem [0:MAX_NODES-1];
  logic [VAL_W-1:0]        nxt_q;

  logic                    row_we, row_re;
  logic [NODE_CNT_W-1:0]   row_addr;
  logic                    edge_we, edge_re;
  logic                    act_we, act_a_re, act_b_re;
  logic [NODE_IDX_W-1:0]   act_waddr, act_a_addr, act_b_addr;
  logic [VAL_W-1:0]        act_wdata;
  logic                    nxt_we, nxt_re;

  logic signed [VAL_W-1:0] act_a_val, act_b_val;
  assign act_a_val = act_a_vq ? act_a_q : '0;
  assign act_b_val = act_b_vq ? act_b_q : '0;

  // final value of the node update
  logic signed [SUM_W-SHIFT-1:0] sh;
  logic signed [VAL_W-1:0]       nv_sat, nv, nxt_val;

  always_comb begin
    sh = sum_r[SUM_W-1:SHIFT];
    if (sh > $signed({{(SUM_W-SHIFT-VAL_W){1'b0}}, 1'b0, {(VAL_W-1){1'b1}}}))
      nv_sat = {1'b0, {(VAL_W-1){1'b1}}};
    else if (sh < $signed({{(SUM_W-SHIFT-VAL_W){1'b1}}, 1'b1, {(VAL_W-1){1'b0}}}))
      nv_sat = {1'b1, {(VAL_W-1){1'b0}}};
    else
      nv_sat = sh[VAL_W-1:0];
    nv      = (nv_sat < thr_r) ? '0 : nv_sat;
    nxt_val = (old_r > nv) ? old_r : nv;
  end

  // shared multiplier: edge products and both halves of acc * decay
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [VAL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = decay_r;
    case (state_r)
      S_E3: begin
        mul_b = w_q;
        if ({1'b0, nb_q} < n_r)
          mul_a = {{(MUL_A_W-VAL_W){act_a_val[VAL_W-1]}}, act_a_val};
      end
      S_D1: mul_a = {1'b0, acc_r[SPLIT-1:0]};
      S_D2: mul_a = {acc_r[ACC_W-1], acc_r[ACC_W-1:SPLIT]};
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // memory control
  always_comb begin
    row_we     = in_acc && (in_cmd == CMD_ROW) && (in_slot <= EDGE_CNT_W'(MAX_NODES));
    edge_we    = in_acc && (in_cmd == CMD_EDGE) && (in_slot < EDGE_CNT_W'(MAX_EDGES));
    row_re     = (state_r == S_RA) || (state_r == S_RB);
    row_addr   = (state_r == S_RB) ? i_r + NODE_CNT_W'(1) : i_r;
    edge_re    = (state_r == S_E1);
    act_a_re   = (state_r == S_E2);
    act_a_addr = nb_q;
    act_b_re   = (state_r == S_RA) || (state_r == S_ERD);
    act_b_addr = i_r[NODE_IDX_W-1:0];
    nxt_we     = (state_r == S_D4);
    nxt_re     = (state_r == S_CPR);
    if (state_r == S_CPW) begin
      act_we    = 1'b1;
      act_waddr = i_r[NODE_IDX_W-1:0];
      act_wdata = nxt_q;
    end else begin
      act_we    = in_acc && (in_cmd == CMD_SEED) && (in_slot < EDGE_CNT_W'(MAX_NODES));
      act_waddr = in_slot[NODE_IDX_W-1:0];
      act_wdata = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[in_slot[NODE_CNT_W-1:0]] <= in_offset;
    if (row_re) row_q <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      nb_mem[in_slot[EDGE_IDX_W-1:0]] <= in_nb;
      w_mem[in_slot[EDGE_IDX_W-1:0]]  <= in_value;
    end
    if (edge_re) begin
      nb_q <= nb_mem[e_r[EDGE_IDX_W-1:0]];
      w_q  <= w_mem[e_r[EDGE_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (act_we) act_mem[act_waddr] <= act_wdata;
    if (act_a_re) act_a_q <= act_mem[act_a_addr];
    if (act_b_re) act_b_q <= act_mem[act_b_addr];
  end

  // valid bits stand in for the all-zero reset of the activation memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r <= '0;
      act_a_vq  <= 1'b0;
      act_b_vq  <= 1'b0;
    end else begin
      if (act_we) act_vld_r[act_waddr] <= 1'b1;
      if (act_a_re) act_a_vq <= act_vld_r[act_a_addr];
      if (act_b_re) act_b_vq <= act_vld_r[act_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[i_r[NODE_IDX_W-1:0]] <= nxt_val;
    if (nxt_re) nxt_q <= nxt_mem[i_r[NODE_IDX_W-1:0]];
  end

  // sequencer
  logic [NODE_CNT_W-1:0] n_use;
  logic                  i_last;
  assign n_use  = (node_count_r > NODE_CNT_W'(MAX_NODES)) ? NODE_CNT_W'(MAX_NODES)
                                                           : node_count_r;
  assign i_last = (i_r + NODE_CNT_W'(1)) == n_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      n_r         <= '0;
      h_r         <= '0;
      hops_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_cmd == CMD_RUN) && (n_use != '0)) begin
            n_r    <= n_use;
            i_r    <= '0;
            h_r    <= '0;
            elim_r <= (edge_count_r > EDGE_CNT_W'(MAX_EDGES)) ? EDGE_CNT_W'(MAX_EDGES)
                                                              : edge_count_r;
            if (edge_count_r != '0) begin
              hops_r  <= hop_count_r;
              state_r <= (hop_count_r == '0) ? S_ERD : S_RA;
            end else begin
              hops_r  <= '0;
              state_r <= S_ERD;
            end
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          e_r     <= row_q;
          state_r <= S_RC;
        end
        S_RC: begin
          old_r   <= act_b_val;
          end_r   <= (row_q > elim_r) ? elim_r : row_q;
          acc_r   <= '0;
          state_r <= S_E1;
        end
        S_E1: state_r <= (e_r < end_r) ? S_E2 : S_D1;
        S_E2: state_r <= S_E3;
        S_E3: state_r <= S_E4;
        S_E4: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          e_r     <= e_r + EDGE_CNT_W'(1);
          state_r <= S_E1;
        end
        S_D1: state_r <= S_D2;
        S_D2: begin
          // low partial product plus the rounding half
          sum_r   <= SUM_W'(prod_r) + (SUM_W'(1) <<< (SHIFT - 1));
          state_r <= S_D3;
        end
        S_D3: begin
          sum_r   <= sum_r + (SUM_W'(prod_r) <<< SPLIT);
          state_r <= S_D4;
        end
        S_D4: begin
          if (i_last) begin
            i_r     <= '0;
            state_r <= S_CPR;
          end else begin
            i_r     <= i_r + NODE_CNT_W'(1);
            state_r <= S_RA;
          end
        end
        S_CPR: state_r <= S_CPW;
        S_CPW: begin
          if (i_last) begin
            i_r     <= '0;
            h_r     <= h_r + HOP_W'(1);
            state_r <= ((h_r + HOP_W'(1)) == hops_r) ? S_ERD : S_RA;
          end else begin
            i_r     <= i_r + NODE_CNT_W'(1);
            state_r <= S_CPR;
          end
        end
        S_ERD: state_r <= S_ECAP;
        S_ECAP: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_node_r  <= i_r[NODE_IDX_W-1:0];
            out_act_r   <= act_b_val;
            out_hops_r  <= hops_r;
            out_last_r  <= i_last;
          end else if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + NODE_CNT_W'(1);
              state_r <= S_ERD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_hops_r, out_act_r, out_node_r};

  // a result is only shown while the input side is closed
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("result shown while taking input");

  // the transaction marked last reports the final node in use
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> ({1'b0, out_tdata[5:0]} == (n_r - NODE_CNT_W'(1))))
    else $error("last transaction on wrong node");

  // a node update never lowers the activation
  assert property (@(posedge clk) disable iff (!rst_n) nxt_we |-> (nxt_val >= old_r))
    else $error("activation decreased");

  // the edge walk never runs past the cut edge range
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E2) |-> (e_r < elim_r))
    else $error("edge index beyond edge count");

endmodule
`default_nettype wire
